@@ sv/kmc_pkg.sv @@
// Package for the 2D k-means clusterer: widths, item kinds, states and the
// structs that link the distance cells. No dependencies.
package kmc_pkg;

  localparam int unsigned MAX_POINTS   = 1024;
  localparam int unsigned MAX_CLUSTERS = 16;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned PT_AW        = $clog2(MAX_POINTS);
  localparam int unsigned CL_W         = $clog2(MAX_CLUSTERS);
  localparam int unsigned K_W          = CL_W + 1;
  localparam int unsigned N_W          = PT_AW + 1;
  localparam int unsigned IT_W         = 8;
  localparam int unsigned SUM_W        = COORD_W + PT_AW + 1;
  localparam int unsigned CNT_W        = PT_AW + 1;
  localparam int unsigned SQ_W         = 2 * COORD_W;
  localparam int unsigned DIST_W       = SQ_W + 2;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD_PT = 2'd0,
    KIND_LOAD_CT = 2'd1,
    KIND_RUN     = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FEED,
    S_DRAIN,
    S_DIV_PICK,
    S_DIV_X,
    S_DIV_Y,
    S_EMIT
  } state_t;

  // Point travelling down the chain with the best match found so far.
  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [DIST_W-1:0]         best;
    logic [CL_W-1:0]           sel;
  } link_t;

  // Broadcast control to every cell.
  typedef struct packed {
    logic                      clear;
    logic                      acc_valid;
    logic [CL_W-1:0]           acc_sel;
    logic signed [COORD_W-1:0] acc_x;
    logic signed [COORD_W-1:0] acc_y;
    logic                      ld_valid;
    logic [CL_W-1:0]           ld_idx;
    logic signed [COORD_W-1:0] ld_x;
    logic signed [COORD_W-1:0] ld_y;
    logic [K_W-1:0]            k;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic [CNT_W-1:0]          cnt;
  } cell_stat_t;

endpackage

@@ sv/kmc_in_if.sv @@
// Input channel of the k-means clusterer: valid/ready plus the item fields.
// Depends on kmc_pkg for field widths.
interface kmc_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         kind;
  logic [kmc_pkg::IDX_W-1:0]          index;
  logic signed [kmc_pkg::COORD_W-1:0] coord_x;
  logic signed [kmc_pkg::COORD_W-1:0] coord_y;

  modport source (output valid, kind, index, coord_x, coord_y, input ready);
  modport sink   (input valid, kind, index, coord_x, coord_y, output ready);
endinterface

@@ sv/kmc_out_if.sv @@
// Result channel of the k-means clusterer: valid/ready plus the result fields.
// Depends on kmc_pkg for field widths.
interface kmc_out_if;
  logic                               valid;
  logic                               ready;
  logic [kmc_pkg::IDX_W-1:0]          item_index;
  logic signed [kmc_pkg::COORD_W-1:0] out_x;
  logic signed [kmc_pkg::COORD_W-1:0] out_y;
  logic [kmc_pkg::CL_W-1:0]           assigned_cluster;
  logic                               last;

  modport source (output valid, item_index, out_x, out_y, assigned_cluster, last,
                  input ready);
  modport sink   (input valid, item_index, out_x, out_y, assigned_cluster, last,
                  output ready);
endinterface

@@ sv/kmeans_cluster_2d.sv @@
// Lloyd k-means on 2D Q8.8 points. A read item looks up the cluster store as it is
// accepted, and the result is registered from the read state. Each pass of a run
// feeds every point through the cell chain, then the serial divider updates each
// non-empty cluster, while an empty one keeps its centroid; the run then emits one
// centroid per cycle while the receiver is ready.
// Synchronous active-low reset clears control state and the configuration
// registers (2 clusters, 5 passes, 10 points); stores need no clearing pass.
module kmeans_cluster_2d (
  input  logic                              clk,
  input  logic                              rst_n,
  kmc_in_if.sink                            in_ch,
  kmc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kmc_pkg::*;

  // The chain holds two registers per cell; the drain wait covers the point
  // RAM read, the whole chain and the final accumulate.
  localparam int unsigned DRAIN_LEN = 2 * MAX_CLUSTERS + 4;
  localparam int unsigned DRAIN_W   = $clog2(DRAIN_LEN);

  // Configuration registers.
  logic [K_W-1:0]  cl_cfg_r;
  logic [IT_W-1:0] it_cfg_r;
  logic [N_W-1:0]  pt_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_cfg_r <= K_W'(2);
      it_cfg_r <= IT_W'(5);
      pt_cfg_r <= N_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLUSTER_COUNT:   cl_cfg_r <= cfg_data[K_W-1:0];
        CFG_ITERATION_COUNT: it_cfg_r <= cfg_data[IT_W-1:0];
        CFG_POINT_COUNT:     pt_cfg_r <= cfg_data[N_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective cluster and point counts after clamping.
  logic [K_W-1:0] kk;
  logic [N_W-1:0] nn;
  assign kk = (cl_cfg_r == '0) ? K_W'(1) :
              (cl_cfg_r > K_W'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) : cl_cfg_r;
  assign nn = (pt_cfg_r > N_W'(MAX_POINTS)) ? N_W'(MAX_POINTS) : pt_cfg_r;

  // Control registers and their next values.
  state_t              state_r, state_nxt;
  logic [N_W-1:0]      feed_cnt_r, feed_cnt_nxt;
  logic [DRAIN_W-1:0]  drain_r, drain_nxt;
  logic [IT_W-1:0]     iter_r, iter_nxt;
  logic [K_W-1:0]      jdx_r, jdx_nxt;
  logic [N_W-1:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic signed [COORD_W-1:0] qx_r, qx_nxt;
  logic                feed_vld_r;
  logic [IDX_W-1:0]    feed_idx_r;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_idx_r, out_idx_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt;
  logic signed [COORD_W-1:0] out_y_r, out_y_nxt;
  logic [CL_W-1:0]           out_cl_r, out_cl_nxt;
  logic                      out_last_r, out_last_nxt;

  // Datapath signals.
  logic                      in_ready;
  logic                      in_acc;
  logic                      pt_we;
  logic [2*COORD_W-1:0]      pt_rdata;
  logic [CL_W-1:0]           cl_rdata;
  logic                      feed_re;
  logic                      div_start;
  logic signed [SUM_W-1:0]   div_a;
  logic                      div_done;
  logic signed [SUM_W-1:0]   div_q;
  cell_ctl_t                 ctl;
  link_t                     chain [MAX_CLUSTERS+1];
  cell_stat_t                stat  [MAX_CLUSTERS];
  cell_stat_t                cur;

  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign cur          = stat[jdx_r[CL_W-1:0]];

  // Point store: x in the upper half, y in the lower half.
  kmc_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (in_ch.index[PT_AW-1:0]),
    .wdata ({in_ch.coord_x, in_ch.coord_y}),
    .raddr (feed_cnt_r[PT_AW-1:0]),
    .rdata (pt_rdata)
  );

  // Cluster store, written as points leave the chain. Entries at or above
  // fill_r were never written since reset and read as zero.
  kmc_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_cl_ram (
    .clk   (clk),
    .we    (chain[MAX_CLUSTERS].valid),
    .waddr (chain[MAX_CLUSTERS].idx[PT_AW-1:0]),
    .wdata (chain[MAX_CLUSTERS].sel),
    .raddr (in_ch.index[PT_AW-1:0]),
    .rdata (cl_rdata)
  );

  // Head of the chain: a point fresh from the store with no match yet, so
  // the first active cell always takes it.
  assign chain[0] = '{valid: feed_vld_r, idx: feed_idx_r,
                      px: pt_rdata[2*COORD_W-1:COORD_W], py: pt_rdata[COORD_W-1:0],
                      best: '1, sel: '0};

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmc_cell #(.CELL_ID(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .link_i (chain[g]),
      .link_o (chain[g+1]),
      .ctl    (ctl),
      .stat   (stat[g])
    );
  end

  kmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (cur.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    feed_cnt_nxt  = feed_cnt_r;
    drain_nxt     = drain_r;
    iter_nxt      = iter_r;
    jdx_nxt       = jdx_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    qx_nxt        = qx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_cl_nxt    = out_cl_r;
    out_last_nxt  = out_last_r;
    pt_we         = 1'b0;
    feed_re       = 1'b0;
    div_start     = 1'b0;
    div_a         = cur.sum_x;
    ctl           = '0;
    ctl.k         = kk;
    // Points leaving the chain are added to their cluster's sums.
    ctl.acc_valid = chain[MAX_CLUSTERS].valid;
    ctl.acc_sel   = chain[MAX_CLUSTERS].sel;
    ctl.acc_x     = chain[MAX_CLUSTERS].px;
    ctl.acc_y     = chain[MAX_CLUSTERS].py;
    in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind_t'(in_ch.kind))
            KIND_LOAD_PT: pt_we = 1'b1;
            KIND_LOAD_CT: begin
              if (in_ch.index < IDX_W'(MAX_CLUSTERS)) begin
                ctl.ld_valid = 1'b1;
                ctl.ld_idx   = in_ch.index[CL_W-1:0];
                ctl.ld_x     = in_ch.coord_x;
                ctl.ld_y     = in_ch.coord_y;
              end
            end
            KIND_RUN: begin
              iter_nxt = '0;
              jdx_nxt  = '0;
              if (it_cfg_r == '0) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt    = S_FEED;
                feed_cnt_nxt = '0;
                ctl.clear    = 1'b1;
                fill_nxt     = (nn > fill_r) ? nn : fill_r;
              end
            end
            KIND_READ: begin
              rd_idx_nxt = in_ch.index;
              state_nxt  = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = rd_idx_r;
        out_x_nxt     = '0;
        out_y_nxt     = '0;
        out_cl_nxt    = ({1'b0, rd_idx_r} < fill_r) ? cl_rdata : '0;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FEED: begin
        if (feed_cnt_r < nn) begin
          feed_re      = 1'b1;
          feed_cnt_nxt = feed_cnt_r + 1'b1;
        end else begin
          state_nxt = S_DRAIN;
          drain_nxt = '0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DRAIN_W'(DRAIN_LEN - 1)) begin
          state_nxt = S_DIV_PICK;
          jdx_nxt   = '0;
        end
      end
      S_DIV_PICK: begin
        if (jdx_r == kk) begin
          iter_nxt = iter_r + 1'b1;
          jdx_nxt  = '0;
          if (({1'b0, iter_r} + 1'b1) == {1'b0, it_cfg_r}) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt    = S_FEED;
            feed_cnt_nxt = '0;
            ctl.clear    = 1'b1;
          end
        end else if (cur.cnt == '0) begin
          // Empty cluster keeps its centroid.
          jdx_nxt = jdx_r + 1'b1;
        end else begin
          div_start = 1'b1;
          div_a     = cur.sum_x;
          state_nxt = S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_done) begin
          qx_nxt    = div_q[COORD_W-1:0];
          div_start = 1'b1;
          div_a     = cur.sum_y;
          state_nxt = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_done) begin
          ctl.ld_valid = 1'b1;
          ctl.ld_idx   = jdx_r[CL_W-1:0];
          ctl.ld_x     = qx_r;
          ctl.ld_y     = div_q[COORD_W-1:0];
          jdx_nxt      = jdx_r + 1'b1;
          state_nxt    = S_DIV_PICK;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(jdx_r[CL_W-1:0]);
          out_x_nxt     = cur.cx;
          out_y_nxt     = cur.cy;
          out_cl_nxt    = '0;
          out_last_nxt  = (jdx_r + 1'b1) == kk;
          jdx_nxt       = jdx_r + 1'b1;
          if ((jdx_r + 1'b1) == kk) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      feed_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      feed_vld_r  <= feed_re;
    end
  end

  always_ff @(posedge clk) begin
    feed_cnt_r <= feed_cnt_nxt;
    feed_idx_r <= feed_cnt_r[IDX_W-1:0];
    drain_r    <= drain_nxt;
    iter_r     <= iter_nxt;
    jdx_r      <= jdx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    qx_r       <= qx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_cl_r   <= out_cl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.item_index       = out_idx_r;
  assign out_ch.out_x            = out_x_r;
  assign out_ch.out_y            = out_y_r;
  assign out_ch.assigned_cluster = out_cl_r;
  assign out_ch.last             = out_last_r;

  // Points only leave the chain while a pass is feeding or draining.
  a_chain_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_CLUSTERS].valid |-> (state_r == S_FEED || state_r == S_DRAIN))
    else $error("point left the chain outside a pass");

  // The divider only finishes while the update sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_X || state_r == S_DIV_Y))
    else $error("divider finished with no update waiting");

  // Emitting never walks past the clusters in use.
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> jdx_r < kk)
    else $error("centroid emit index out of range");

  // A divide is only started for a cluster with members.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> cur.cnt != '0)
    else $error("divide started on an empty cluster");
endmodule

@@ sv/kmc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/kmc_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Divides a signed cluster sum by its member count. Depends on kmc_pkg.
module kmc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [kmc_pkg::SUM_W-1:0] dividend,
  input  logic [kmc_pkg::CNT_W-1:0]        divisor,
  output logic                             done,
  output logic signed [kmc_pkg::SUM_W-1:0] quotient
);
  import kmc_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  divs_r;
  logic              neg_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, divs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        neg_r  <= dividend[SUM_W-1];
        quo_r  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
        divs_r <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? CNT_W'(trial - {1'b0, divs_r}) : CNT_W'(trial);
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? SUM_W'(-quo_r) : quo_r;
endmodule

@@ sv/kmc_cell.sv @@
// One distance cell: holds one centroid and its running sums, compares the
// passing point against its centroid and hands it on. Depends on kmc_pkg.
module kmc_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmc_pkg::link_t      link_i,
  output kmc_pkg::link_t      link_o,
  input  kmc_pkg::cell_ctl_t  ctl,
  output kmc_pkg::cell_stat_t stat
);
  import kmc_pkg::*;

  link_t                     s1_r;
  link_t                     s2_r;
  logic [SQ_W-1:0]           sqx_r;
  logic [SQ_W-1:0]           sqy_r;
  logic signed [COORD_W-1:0] cx_r;
  logic signed [COORD_W-1:0] cy_r;
  logic signed [SUM_W-1:0]   sum_x_r;
  logic signed [SUM_W-1:0]   sum_y_r;
  logic [CNT_W-1:0]          cnt_r;

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [COORD_W:0]        adx;
  logic [COORD_W:0]        ady;
  logic [SQ_W:0]           dist_sum;
  logic                    active;
  logic                    take;

  assign active = K_W'(CELL_ID) < ctl.k;

  always_comb begin
    dx       = {link_i.px[COORD_W-1], link_i.px} - {cx_r[COORD_W-1], cx_r};
    dy       = {link_i.py[COORD_W-1], link_i.py} - {cy_r[COORD_W-1], cy_r};
    adx      = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ady      = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    take     = active && ({1'b0, dist_sum} < s1_r.best);
  end

  // Two stages: squares, then sum and compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      s1_r  <= link_i;
      sqx_r <= adx[COORD_W-1:0] * adx[COORD_W-1:0];
      sqy_r <= ady[COORD_W-1:0] * ady[COORD_W-1:0];
      s2_r  <= s1_r;
      if (take) begin
        s2_r.best <= {1'b0, dist_sum};
        s2_r.sel  <= CL_W'(CELL_ID);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_valid && ctl.ld_idx == CL_W'(CELL_ID)) begin
      cx_r <= ctl.ld_x;
      cy_r <= ctl.ld_y;
    end
    if (ctl.clear) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else if (ctl.acc_valid && ctl.acc_sel == CL_W'(CELL_ID)) begin
      sum_x_r <= sum_x_r + {{(SUM_W-COORD_W){ctl.acc_x[COORD_W-1]}}, ctl.acc_x};
      sum_y_r <= sum_y_r + {{(SUM_W-COORD_W){ctl.acc_y[COORD_W-1]}}, ctl.acc_y};
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  assign link_o = s2_r;
  assign stat   = '{cx: cx_r, cy: cy_r, sum_x: sum_x_r, sum_y: sum_y_r, cnt: cnt_r};
endmodule

@@ tb/kmc_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the 2D k-means clusterer: watches the item, result and
// register ports, predicts every result and compares. Depends on kmc_pkg and
// the two channel interfaces.
module kmc_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  kmc_in_if                              in_mon,
  kmc_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import kmc_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CL_W-1:0]           cl;
    logic                      last;
  } centroid_result_t;

  centroid_result_t expected_results[$];

  longint      pt_x [MAX_POINTS];
  longint      pt_y [MAX_POINTS];
  int unsigned pt_cluster [MAX_POINTS];
  longint      ct_x [MAX_CLUSTERS];
  longint      ct_y [MAX_CLUSTERS];

  logic [4:0]  clusters_cfg;
  logic [7:0]  passes_cfg;
  logic [10:0] points_cfg;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // One assignment pass followed by the centroid update.
  task automatic lloyd_pass(input int k, input int n);
    longint sum_x [MAX_CLUSTERS];
    longint sum_y [MAX_CLUSTERS];
    longint members [MAX_CLUSTERS];
    longint best, sq_sum, dx, dy;
    for (int i = 0; i < n; i++) begin
      best = 0;
      for (int j = 0; j < k; j++) begin
        dx = pt_x[i] - ct_x[j];
        dy = pt_y[i] - ct_y[j];
        sq_sum = dx * dx + dy * dy;
        if (j == 0 || sq_sum < best) begin
          best = sq_sum;
          pt_cluster[i] = j;
        end
      end
    end
    for (int j = 0; j < MAX_CLUSTERS; j++) begin
      sum_x[j] = 0;
      sum_y[j] = 0;
      members[j] = 0;
    end
    for (int i = 0; i < n; i++) begin
      sum_x[pt_cluster[i]] += pt_x[i];
      sum_y[pt_cluster[i]] += pt_y[i];
      members[pt_cluster[i]]++;
    end
    // Signed division truncates toward zero, as the block does.
    for (int j = 0; j < k; j++) begin
      if (members[j] != 0) begin
        ct_x[j] = sum_x[j] / members[j];
        ct_y[j] = sum_y[j] / members[j];
      end
    end
  endtask

  task automatic mismatch(input string field, input longint exp_v, input longint got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    centroid_result_t r;
    int k, n;
    if (!rst_n) begin
      clusters_cfg = 5'd2;
      passes_cfg = 8'd5;
      points_cfg = 11'd10;
      for (int i = 0; i < MAX_POINTS; i++) pt_cluster[i] = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLUSTER_COUNT:   clusters_cfg = cfg_data[4:0];
          CFG_ITERATION_COUNT: passes_cfg = cfg_data[7:0];
          CFG_POINT_COUNT:     points_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        case (kind_t'(in_mon.kind))
          KIND_LOAD_PT: begin
            pt_x[in_mon.index] = in_mon.coord_x;
            pt_y[in_mon.index] = in_mon.coord_y;
          end
          KIND_LOAD_CT: begin
            if (in_mon.index < MAX_CLUSTERS) begin
              ct_x[in_mon.index] = in_mon.coord_x;
              ct_y[in_mon.index] = in_mon.coord_y;
            end
          end
          KIND_READ: begin
            r.idx = in_mon.index;
            r.x = '0;
            r.y = '0;
            r.cl = CL_W'(pt_cluster[in_mon.index]);
            r.last = 1'b1;
            expected_results.push_back(r);
          end
          default: begin
            k = (clusters_cfg == 0) ? 1 : (clusters_cfg > MAX_CLUSTERS) ? MAX_CLUSTERS
                                                                         : clusters_cfg;
            n = (points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg;
            for (int p = 0; p < passes_cfg; p++) lloyd_pass(k, n);
            for (int j = 0; j < k; j++) begin
              r.idx = IDX_W'(j);
              r.x = COORD_W'(ct_x[j]);
              r.y = COORD_W'(ct_y[j]);
              r.cl = '0;
              r.last = (j == k - 1);
              expected_results.push_back(r);
            end
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, index %0d", $time,
                   out_mon.item_index);
          fail_count++;
        end else begin
          r = expected_results.pop_front();
          if (out_mon.item_index !== r.idx) mismatch("item_index", r.idx, out_mon.item_index);
          if (out_mon.out_x !== r.x) mismatch("out_x", r.x, out_mon.out_x);
          if (out_mon.out_y !== r.y) mismatch("out_y", r.y, out_mon.out_y);
          if (out_mon.assigned_cluster !== r.cl)
            mismatch("assigned_cluster", r.cl, out_mon.assigned_cluster);
          if (out_mon.last !== r.last) mismatch("last", r.last, out_mon.last);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ tb/tb_kmeans_cluster_2d.sv @@
`timescale 1ns / 100ps
// Top of the k-means clusterer testbench: clock, reset, item stimulus and the
// verdict. Depends on kmc_pkg, the channel interfaces and kmc_result_checker.
module tb_kmeans_cluster_2d;
  import kmc_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // longest quiet stretch is one 255-pass run.
  localparam int HANG_LIMIT = 400000;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 16;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kmc_in_if  in_ch ();
  kmc_out_if out_ch ();

  int fail_count;
  int pending;
  int send_pct;
  int recv_pct;
  int quiet_cycles;
  int item_total;
  int run_total;
  int read_total;
  int random_items;
  int cur_k;
  int cur_n;
  int centers [4];
  bit pt_loaded [MAX_POINTS];
  bit ct_loaded [MAX_CLUSTERS];

  kmeans_cluster_2d u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kmc_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides anew at every falling edge whether to take a result.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, HANG_LIMIT, pending);
      $display("tb_kmeans_cluster_2d: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Coordinates are mostly grouped around a few centers so that the passes
  // actually move centroids; the rest cover the full range and its extremes.
  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 65535)) - 32768;
      1:       return $urandom_range(0, 1) ? 32767 : -32768;
      default: return centers[$urandom_range(0, 3)] + int'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  // Presents one item and returns once it has been accepted. Valid stays high
  // for the caller's next item unless the sender chooses to idle first.
  task automatic send_item(input kind_t kd, input int idx, input int x, input int y);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kd;
    in_ch.index   <= idx[IDX_W-1:0];
    in_ch.coord_x <= x[COORD_W-1:0];
    in_ch.coord_y <= y[COORD_W-1:0];
    if (kd == KIND_LOAD_PT) pt_loaded[idx] = 1'b1;
    if (kd == KIND_LOAD_CT && idx < MAX_CLUSTERS) ct_loaded[idx] = 1'b1;
    if (kd == KIND_RUN) run_total++;
    if (kd == KIND_READ) read_total++;
    item_total++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drops valid and waits until every predicted result has come out, plus a
  // margin in case the block is still finishing internal work.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic set_config(input int k, input int passes, input int n);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLUSTER_COUNT;
    cfg_data  <= k[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_ITERATION_COUNT;
    cfg_data  <= passes[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_POINT_COUNT;
    cfg_data  <= n[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    k = k & 31;
    cur_k = (k == 0) ? 1 : (k > MAX_CLUSTERS) ? MAX_CLUSTERS : k;
    cur_n = (n > MAX_POINTS) ? MAX_POINTS : n;
  endtask

  // A run must never touch a point or centroid that was never written, so
  // anything the current setting uses is loaded before the first run.
  task automatic load_missing();
    for (int i = 0; i < cur_n; i++)
      if (!pt_loaded[i]) send_item(KIND_LOAD_PT, i, pick_coord(), pick_coord());
    for (int j = 0; j < cur_k; j++)
      if (!ct_loaded[j]) send_item(KIND_LOAD_CT, j, pick_coord(), pick_coord());
  endtask

  // One random setting followed by a burst of mixed items. Most often loads of
  // the points in use, some centroid loads (a few to ignored indexes), reads
  // and runs.
  task automatic random_round();
    int sel, idx, span;
    if ($urandom_range(0, 4) == 0) set_config($urandom_range(9, 16), $urandom_range(1, 2),
                                              $urandom_range(4, 40));
    else set_config($urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 32));
    load_missing();
    repeat ($urandom_range(8, 14)) begin
      sel = $urandom_range(0, 99);
      span = (cur_n + 3 > MAX_POINTS - 1) ? MAX_POINTS - 1 : cur_n + 3;
      idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_POINTS - 1)
                                        : $urandom_range(0, span);
      if (sel < 45) send_item(KIND_LOAD_PT, idx, pick_coord(), pick_coord());
      else if (sel < 58) send_item(KIND_LOAD_CT, $urandom_range(0, 19), pick_coord(),
                                   pick_coord());
      else if (sel < 80) send_item(KIND_READ, idx, pick_coord(), pick_coord());
      else send_item(KIND_RUN, idx, pick_coord(), pick_coord());
      random_items++;
    end
  endtask

  initial begin
    int modes_send [3] = '{34, 63, 0};
    int modes_recv [3] = '{63, 34, 0};
    int extremes_x [10] = '{32767, -32768, 0, -1, 1, 32767, -32768, 256, -256, 21845};
    int extremes_y [10] = '{-32768, 32767, 0, -1, 1, 32767, -32768, -256, 256, -21846};

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD_PT;
    in_ch.index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    quiet_cycles = 0;
    send_pct = modes_send[0];
    recv_pct = modes_recv[0];
    foreach (centers[i]) centers[i] = int'($urandom_range(0, 40000)) - 20000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset setting: extreme coordinates, ignored
    // centroid loads, reads before any run (cluster zero), then a run and two reads.
    cur_k = 2;
    cur_n = 10;
    send_item(KIND_READ, MAX_POINTS - 1, 0, 0);
    send_item(KIND_LOAD_CT, 0, -32768, 32767);
    send_item(KIND_LOAD_CT, 1, 32767, -32768);
    send_item(KIND_LOAD_CT, MAX_CLUSTERS, 100, 100);
    send_item(KIND_LOAD_CT, MAX_POINTS - 1, -100, -100);
    for (int i = 0; i < 10; i++) send_item(KIND_LOAD_PT, i, extremes_x[i], extremes_y[i]);
    send_item(KIND_READ, 0, 0, 0);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_READ, 1, 0, 0);
    send_item(KIND_READ, 9, 0, 0);

    // Zero clusters, zero passes and zero points: one centroid, unchanged.
    set_config(0, 0, 0);
    send_item(KIND_RUN, 0, 0, 0);

    // Two identical centroids: every tie has to go to the lower index.
    set_config(4, 1, 4);
    load_missing();
    send_item(KIND_LOAD_CT, 2, 0, 0);
    send_item(KIND_LOAD_CT, 3, 0, 0);
    send_item(KIND_LOAD_PT, 3, 0, 0);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_READ, 3, 0, 0);

    // Most passes on a tiny set, then more clusters than points.
    set_config(2, 255, 4);
    send_item(KIND_RUN, 0, 0, 0);
    set_config(16, 3, 8);
    load_missing();
    send_item(KIND_RUN, 0, 0, 0);

    // A cluster count beyond the maximum saturates, and a point that no run
    // has reached still reads as cluster zero.
    set_config(31, 1, 20);
    load_missing();
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_READ, MAX_POINTS - 1, 0, 0);
    set_config(1, 1, 1);
    send_item(KIND_RUN, 0, 0, 0);

    // Random rounds under each idling pattern in turn.
    random_items = 0;
    for (int m = 0; m < 3; m++) begin
      send_pct = modes_send[m];
      recv_pct = modes_recv[m];
      while (random_items < (m + 1) * 120) random_round();
    end

    settle();
    $display("Covered %0d items: %0d runs and %0d reads over saturated, zero and random",
             item_total, run_total, read_total);
    $display("cluster, pass and point counts under three idling patterns.");
    if (fail_count == 0) begin
      $display("tb_kmeans_cluster_2d: clean");
    end else begin
      $display("tb_kmeans_cluster_2d: errors");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/kmc_pkg.sv
sv/kmc_in_if.sv
sv/kmc_out_if.sv
sv/kmc_ram.sv
sv/kmc_div.sv
sv/kmc_cell.sv
sv/kmeans_cluster_2d.sv
tb/kmc_result_checker.sv
tb/tb_kmeans_cluster_2d.sv
